/* src/bas_pkg.sv */
package bas_pkg;

    localparam int MAX_BLOCK  = 16384;
    localparam int COUNT_BITS = 24;
    localparam int BS_BITS    = 15;
    localparam int PSUM_BITS  = 46;
    localparam int SOM_BITS   = 56;
    localparam int DIV_BITS   = 64;
    localparam int DVS_BITS   = 24;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_sample;
    } in_t;

    typedef struct packed {
        logic signed [31:0] mean;
        logic [30:0]        std_error;
        logic [23:0]        block_count;
        logic               status;
    } out_t;

    // One entry handed from the front to the back.
    typedef struct packed {
        logic                        close;
        logic                        last;
        logic signed [PSUM_BITS-1:0] sum;
        logic [BS_BITS-1:0]          cnt;
    } ent_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_BDIV,
        B_BSQ,
        B_BACC,
        B_FIN,
        B_MEAN,
        B_MUL,
        B_MSQ,
        B_QSTART,
        B_QDIV,
        B_SQRT,
        B_EMIT
    } bstate_t;

endpackage

/* src/block_average_std_error.sv */
// Blocking-method mean and standard error over a stream of signed Q16.16
// samples. The front takes one sample per cycle unless the queue is full,
// and hands each closed block (and the last-sample marker) to the back
// through a four-entry queue. The back runs a shared serial divider, so
// the input stalls on full when blocks close faster than the back can
// process them. With at least two blocks, the final result takes three
// divisions plus a 32-step square root after the last sample's blocks are
// processed. Write block_size only while the block is idle; zero acts as 1
// and values above 16384 act as 16384.
module block_average_std_error
    import bas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_t                in_item,
    output logic               empty,
    input  logic               pop,
    output out_t               out_item,
    input  logic               cfg_wr_en,
    input  logic [BS_BITS-1:0] cfg_wr_data
);

    logic [BS_BITS-1:0] block_size_reg;
    logic               q_push;
    ent_t               q_wdata;
    ent_t               q_rdata;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic               accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            block_size_reg <= BS_BITS'(1);
        else if (cfg_wr_en)
            block_size_reg <= cfg_wr_data;
    end

    bas_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (in_item),
        .block_size (block_size_reg),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    bas_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    bas_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

/* src/bas_front.sv */
module bas_front
    import bas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  in_t                item,
    input  logic [BS_BITS-1:0] block_size,
    output logic               q_push,
    output ent_t               q_data
);

    logic signed [PSUM_BITS-1:0] psum_reg, psum_next;
    logic [BS_BITS-1:0]          fill_reg, fill_next;
    logic [BS_BITS-1:0]          bs_eff;
    logic signed [PSUM_BITS-1:0] sum_n;
    logic [BS_BITS-1:0]          cnt_n;
    logic                        close;

    always_comb
    begin
        if (block_size == '0)
            bs_eff = BS_BITS'(1);
        else if (block_size > BS_BITS'(MAX_BLOCK))
            bs_eff = BS_BITS'(MAX_BLOCK);
        else
            bs_eff = block_size;

        sum_n = psum_reg + PSUM_BITS'(item.sample);
        cnt_n = fill_reg + BS_BITS'(1);
        close = (cnt_n >= bs_eff);

        q_push       = accept && (close || item.last_sample);
        q_data.close = close;
        q_data.last  = item.last_sample;
        q_data.sum   = sum_n;
        q_data.cnt   = cnt_n;

        psum_next = psum_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            // A trailing partial block is dropped along with the series.
            if (close || item.last_sample)
            begin
                psum_next = '0;
                fill_next = '0;
            end
            else
            begin
                psum_next = sum_n;
                fill_next = cnt_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            psum_reg <= psum_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* src/bas_queue.sv */
module bas_queue
    import bas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ent_t wdata,
    input  logic pop,
    output ent_t rdata,
    output logic full,
    output logic empty
);

    ent_t       mem_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        full     = (cnt_reg == 3'd4);
        empty    = (cnt_reg == 3'd0);
        rdata    = mem_reg[rp_reg];
        wp_next  = push ? wp_reg + 2'd1 : wp_reg;
        rp_next  = pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/bas_div.sv */
module bas_div
    import bas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic                done,
    output logic [DIV_BITS-1:0] quotient
);

    // Restoring division, one quotient bit per cycle.
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DVS_BITS:0]   trial;
    logic                ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_BITS-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_BITS-2:0], ge};
            rem_next = ge ? DVS_BITS'(trial - {1'b0, dvs_reg}) : trial[DVS_BITS-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        done     = done_reg;
        quotient = quo_reg;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

/* src/bas_back.sv */
module bas_back
    import bas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  ent_t q_data,
    input  logic q_empty,
    output logic q_pop,
    output logic empty,
    input  logic pop,
    output out_t out_item
);

    bstate_t state_reg, state_next;

    ent_t                       ent_reg;
    logic signed [32:0]         bmean_reg;
    logic [31:0]                bmag_reg;
    logic [63:0]                sq_reg;
    logic [COUNT_BITS-1:0]      blocks_reg;
    logic signed [SOM_BITS-1:0] som_reg;
    logic [63:0]                ssq_reg;
    logic [31:0]                mean_reg;
    logic [31:0]                mmag_reg;
    logic [63:0]                m2_reg;
    logic [63:0]                var_reg;
    logic [63:0]                v_reg;
    logic [63:0]                root_reg;
    logic [63:0]                bit_reg;
    logic [4:0]                 scnt_reg;
    logic                       res_valid_reg;
    out_t                       res_reg;

    logic                  div_start;
    logic [DIV_BITS-1:0]   div_dividend;
    logic [DVS_BITS-1:0]   div_divisor;
    logic                  div_done;
    logic [DIV_BITS-1:0]   div_quot;

    logic                  few;
    logic [PSUM_BITS-1:0]  head_mag;
    logic [SOM_BITS-1:0]   som_mag;
    logic signed [SOM_BITS:0] som_sum;
    logic [64:0]           ssq_sum;
    logic [63:0]           msq;
    logic [63:0]           rb;

    bas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        few      = (blocks_reg < COUNT_BITS'(2));
        head_mag = q_data.sum[PSUM_BITS-1] ? PSUM_BITS'(-q_data.sum) : PSUM_BITS'(q_data.sum);
        som_mag  = som_reg[SOM_BITS-1] ? SOM_BITS'(-som_reg) : SOM_BITS'(som_reg);
        som_sum  = {som_reg[SOM_BITS-1], som_reg} + (SOM_BITS+1)'(bmean_reg);
        ssq_sum  = {1'b0, ssq_reg} + {1'b0, sq_reg};
        msq      = div_quot;
        rb       = root_reg + bit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                    state_next = q_data.close ? B_BDIV : B_FIN;
            B_BDIV:
                if (div_done)
                    state_next = B_BSQ;
            B_BSQ:
                state_next = B_BACC;
            B_BACC:
                state_next = ent_reg.last ? B_FIN : B_IDLE;
            B_FIN:
                state_next = few ? B_EMIT : B_MEAN;
            B_MEAN:
                if (div_done)
                    state_next = B_MUL;
            B_MUL:
                state_next = B_MSQ;
            B_MSQ:
                if (div_done)
                    state_next = B_QSTART;
            B_QSTART:
                state_next = B_QDIV;
            B_QDIV:
                if (div_done)
                    state_next = B_SQRT;
            B_SQRT:
                if (scnt_reg == 5'd31)
                    state_next = B_EMIT;
            B_EMIT:
                if (!res_valid_reg)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_BITS'(som_mag);
        div_divisor  = blocks_reg;
        case (state_reg)
            B_IDLE:
            begin
                q_pop        = !q_empty;
                div_start    = !q_empty && q_data.close;
                div_dividend = DIV_BITS'(head_mag);
                div_divisor  = DVS_BITS'(q_data.cnt);
            end
            B_FIN:
                div_start = !few;
            B_MUL:
            begin
                div_start    = 1'b1;
                div_dividend = ssq_reg;
            end
            B_QSTART:
            begin
                div_start    = 1'b1;
                div_dividend = var_reg;
                div_divisor  = blocks_reg - COUNT_BITS'(1);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
        empty    = !res_valid_reg;
        out_item = res_reg;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                ent_reg <= q_data;
            B_BDIV:
                if (div_done)
                begin
                    bmag_reg  <= div_quot[31:0];
                    bmean_reg <= ent_reg.sum[PSUM_BITS-1] ? -$signed({1'b0, div_quot[31:0]})
                                                          : $signed({1'b0, div_quot[31:0]});
                end
            B_BSQ:
                sq_reg <= bmag_reg * bmag_reg;
            B_MEAN:
                if (div_done)
                begin
                    mmag_reg <= div_quot[31:0];
                    mean_reg <= som_reg[SOM_BITS-1] ? -div_quot[31:0] : div_quot[31:0];
                end
            B_MUL:
                m2_reg <= mmag_reg * mmag_reg;
            B_MSQ:
                if (div_done)
                    var_reg <= (msq > m2_reg) ? msq - m2_reg : '0;
            B_QDIV:
                if (div_done)
                begin
                    v_reg    <= div_quot;
                    root_reg <= '0;
                    bit_reg  <= 64'h4000_0000_0000_0000;
                end
            B_SQRT:
            begin
                if (v_reg >= rb)
                begin
                    v_reg    <= v_reg - rb;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            B_EMIT:
                if (!res_valid_reg)
                begin
                    res_reg.block_count <= blocks_reg;
                    res_reg.status      <= few;
                    if (few)
                    begin
                        res_reg.mean      <= '0;
                        res_reg.std_error <= '0;
                    end
                    else
                    begin
                        res_reg.mean      <= mean_reg;
                        res_reg.std_error <= (root_reg > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                         : root_reg[30:0];
                    end
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            blocks_reg    <= '0;
            som_reg       <= '0;
            ssq_reg       <= '0;
            scnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            case (state_reg)
                B_QDIV:
                    scnt_reg <= '0;
                B_SQRT:
                    scnt_reg <= scnt_reg + 5'd1;
                B_BACC:
                    // A full block counter drops further blocks.
                    if (blocks_reg != '1)
                    begin
                        blocks_reg <= blocks_reg + COUNT_BITS'(1);
                        if (som_sum[SOM_BITS] != som_sum[SOM_BITS-1])
                            som_reg <= som_sum[SOM_BITS] ? {1'b1, {(SOM_BITS-1){1'b0}}}
                                                         : {1'b0, {(SOM_BITS-1){1'b1}}};
                        else
                            som_reg <= som_sum[SOM_BITS-1:0];
                        ssq_reg <= ssq_sum[64] ? '1 : ssq_sum[63:0];
                    end
                B_EMIT:
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        blocks_reg    <= '0;
                        som_reg       <= '0;
                        ssq_reg       <= '0;
                    end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bas_pkg::*;

    localparam longint SUM_HI    = (64'sd1 <<< 55) - 1;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam int     COUNT_TOP = (1 << COUNT_BITS) - 1;
    localparam int     SETTLE    = 400;
    localparam int     STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    in_t                in_item;
    logic               empty;
    logic               pop;
    out_t               out_item;
    logic               cfg_wr_en;
    logic [BS_BITS-1:0] cfg_wr_data;

    block_average_std_error u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Shadow copy of the block's state.
    logic [BS_BITS-1:0] bs_reg;
    int unsigned        fill;
    longint             psum;
    int unsigned        nblocks;
    longint             mean_sum;
    longint unsigned    sq_sum;

    out_t stat_q[$];
    int   errors;
    int   send_idle;
    int   recv_idle;
    int   hold_req;
    int   hold_left;
    int   quiet_cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic void clear_stats();
        fill     = 0;
        psum     = 0;
        nblocks  = 0;
        mean_sum = 0;
        sq_sum   = 0;
    endfunction

    function automatic void fold_block();
        longint          bm;
        longint unsigned mag;
        longint unsigned sq;
        bm   = psum / longint'(fill);
        fill = 0;
        psum = 0;
        if (nblocks >= COUNT_TOP)
            return;
        nblocks++;
        mean_sum += bm;
        if (mean_sum > SUM_HI)
            mean_sum = SUM_HI;
        if (mean_sum < SUM_LO)
            mean_sum = SUM_LO;
        mag = (bm < 0) ? longint'(-bm) : longint'(bm);
        sq  = mag * mag;
        if (sq_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq)
            sq_sum = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            sq_sum += sq;
    endfunction

    function automatic void predict_stats(in_t it);
        int unsigned     eff_bs;
        longint          avg;
        longint unsigned mag;
        longint unsigned m2;
        longint unsigned msq;
        longint unsigned var_q;
        longint unsigned se;
        out_t            r;
        eff_bs = (bs_reg == 0) ? 1 : ((bs_reg > MAX_BLOCK) ? MAX_BLOCK : bs_reg);
        psum += longint'(it.sample);
        fill++;
        if (fill >= eff_bs)
            fold_block();
        if (!it.last_sample)
            return;
        r             = '0;
        r.block_count = nblocks[23:0];
        if (nblocks < 2)
            r.status = 1'b1;
        else
        begin
            avg   = mean_sum / longint'(nblocks);
            mag   = (avg < 0) ? longint'(-avg) : longint'(avg);
            m2    = mag * mag;
            msq   = sq_sum / longint'(nblocks);
            var_q = (msq > m2) ? msq - m2 : 0;
            se    = int_sqrt(var_q / longint'(nblocks - 1));
            if (se > 64'h7FFF_FFFF)
                se = 64'h7FFF_FFFF;
            r.mean      = avg[31:0];
            r.std_error = se[30:0];
        end
        stat_q.push_back(r);
        clear_stats();
    endfunction

    task automatic send_sample(logic [31:0] value, logic last);
        in_t it;
        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        it.sample      = value;
        it.last_sample = last;
        @(negedge clk);
        push    <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        predict_stats(it);
    endtask

    task automatic stop_push();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // Wait until every expected result is back, then let the back end go quiet.
    task automatic settle();
        stop_push();
        while (stat_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_block_size(logic [BS_BITS-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        bs_reg = value;
    endtask

    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (stat_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %p", out_item);
            end
            else
            begin
                out_t want;
                want = stat_q.pop_front();
                if (out_item.mean !== want.mean || out_item.std_error !== want.std_error
                    || out_item.block_count !== want.block_count
                    || out_item.status !== want.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", want, out_item);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL block_average_std_error");
            $finish;
        end
    end

    task automatic test_directed();
        // Extremes with single-sample blocks.
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        // Too few blocks.
        send_sample(32'h1234_5678, 1'b1);
        // Square sum overflows.
        repeat (4) send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        // Standard error reaches its largest value.
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        settle();
        write_block_size('0);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'h0003_8000, 1'b1);
        settle();
        write_block_size('1);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0002_0000, 1'b1);
        settle();
        // Trailing partial block is dropped.
        write_block_size(15'd3);
        for (int i = 0; i < 6; i++)
            send_sample($urandom, 1'b0);
        send_sample($urandom, 1'b1);
        settle();
    endtask

    task automatic test_resize_mid_block();
        write_block_size(15'd4);
        repeat (3) send_sample($urandom, 1'b0);
        settle();
        write_block_size(15'd2);
        repeat (4) send_sample($urandom, 1'b0);
        send_sample($urandom, 1'b1);
        settle();
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        int          sent;
        int          len;
        logic [31:0] base;
        logic [31:0] v;
        send_idle = s_idle;
        recv_idle = r_idle;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(3) == 0)
            begin
                settle();
                if ($urandom_range(9) == 0)
                    write_block_size(BS_BITS'($urandom_range(40, 90)));
                else
                    write_block_size(BS_BITS'($urandom_range(1, 6)));
            end
            len  = $urandom_range(1, 40);
            base = $urandom;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(2) == 0)
                    v = $urandom;
                else
                    v = base + $signed($urandom_range(0, 131071)) - 65536;
                send_sample(v, (i == len - 1) ? 1'b1 : ($urandom_range(99) == 0));
            end
            sent += len;
        end
        settle();
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        write_block_size(15'd1);
        hold_req = 600;
        for (int i = 0; i < 60; i++)
            send_sample($urandom, ($urandom_range(3) == 0));
        send_sample($urandom, 1'b1);
        // Pause until everything has drained, then a short burst.
        settle();
        for (int i = 0; i < 10; i++)
            send_sample($urandom, (i == 9));
        settle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        in_item      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        errors       = 0;
        send_idle    = 0;
        recv_idle    = 0;
        hold_req     = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        bs_reg       = 15'd1;
        clear_stats();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_resize_mid_block();
        test_backpressure();
        test_random(490, 19, 77);
        test_random(490, 77, 19);
        test_random(490, 0, 0);

        if (stat_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("PASS block_average_std_error");
        else
            $display("FAIL block_average_std_error");
        $finish;
    end

endmodule
